// ===== hdl/kvm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key/value table package
// Shared item types, mode codes and the command format passed from the
// front end to the back end of the key/value table.
// ----------------------------------------------------------------------------
package kvm_pkg;

  // Mode codes of an input item.
  localparam logic [1:0] MODE_SET   = 2'd0;
  localparam logic [1:0] MODE_UNSET = 2'd1;
  localparam logic [1:0] MODE_GET   = 2'd2;

  localparam int KeyW = 64;
  localparam int ValW = 64;

  // Decoded operation carried through the command queue.
  typedef enum logic [1:0] {
    OP_SET,
    OP_UNSET,
    OP_GET,
    OP_NOP
  } op_e;

  typedef struct packed {
    logic [1:0]      mode;
    logic [KeyW-1:0] key;
    logic [ValW-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic            found;
    logic [ValW-1:0] read_value;
    logic            table_full;
  } out_item_t;

  typedef struct packed {
    op_e             op;
    logic [KeyW-1:0] key;
    logic [ValW-1:0] value;
  } cmd_t;

endpackage

// ===== hdl/key_value_map_table_top.sv =====
`timescale 1ns / 1ps
// A match ends the scan early, and a get that hits passes through an extra
// read state before its result. The back end takes one item at a time,
// scanning with the single key comparator that reads one slot per cycle
// from the key store. Reset empties the table at once (valid bits
// clear); key and value stores are not cleared.
// ----------------------------------------------------------------------------
// Key/value table top level
// Fixed-capacity key/value table with unique keys: set, unset and get.
// ----------------------------------------------------------------------------
module key_value_map_table_top #(
  parameter int ENTRIES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  kvm_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output kvm_pkg::out_item_t out_item_o
);

  logic          cmd_valid;
  logic          cmd_pop;
  kvm_pkg::cmd_t cmd;

  // Front end: accept, decode and queue.
  kvm_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .cmd_valid_o(cmd_valid),
    .cmd_pop_i  (cmd_pop),
    .cmd_o      (cmd)
  );

  // Back end: slot scan, update and result.
  kvm_back #(.ENTRIES(ENTRIES)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_valid),
    .cmd_pop_o  (cmd_pop),
    .cmd_i      (cmd),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  // The back end never pops an empty queue.
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> cmd_valid) else $error("command popped from empty queue");

  // A full queue always offers a command to the back end.
  a_full_offers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> cmd_valid) else $error("queue full but no command offered");

  // A result never reports both a hit and a dropped pair.
  a_found_xor_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_item_o.found && out_item_o.table_full))
    else $error("result has found and table_full set");

  // A nonzero read value only comes with a hit.
  a_value_needs_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_item_o.read_value != '0)) |-> out_item_o.found)
    else $error("read value without a hit");

endmodule

// ===== hdl/kvm_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module kvm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/kvm_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key/value table front end
// Accepts input items, decodes the mode into an operation and holds the
// decoded commands in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module kvm_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  kvm_pkg::in_item_t in_item_i,
  output logic              cmd_valid_o,
  input  logic              cmd_pop_i,
  output kvm_pkg::cmd_t     cmd_o
);

  kvm_pkg::cmd_t mem_q [2];
  logic          wr_ptr_q;
  logic          rd_ptr_q;
  logic [1:0]    count_q;
  logic          push;
  logic          pop;
  kvm_pkg::cmd_t cmd_in;

  // Decode the mode; the unused code becomes a no-op.
  always_comb begin
    cmd_in.key   = in_item_i.key;
    cmd_in.value = in_item_i.value;
    case (in_item_i.mode)
      kvm_pkg::MODE_SET:   cmd_in.op = kvm_pkg::OP_SET;
      kvm_pkg::MODE_UNSET: cmd_in.op = kvm_pkg::OP_UNSET;
      kvm_pkg::MODE_GET:   cmd_in.op = kvm_pkg::OP_GET;
      default:             cmd_in.op = kvm_pkg::OP_NOP;
    endcase
  end

  assign in_stall_o  = (count_q == 2'd2);
  assign cmd_valid_o = (count_q != 2'd0);
  assign push        = in_valid_i && !in_stall_o;
  assign pop         = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = mem_q[rd_ptr_q];

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= cmd_in;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

// ===== hdl/kvm_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key/value table back end
// Scans the slots with one key comparator, then updates the table and
// places the result in the output register.
// ----------------------------------------------------------------------------
module kvm_back #(
  parameter int ENTRIES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  output logic               cmd_pop_o,
  input  kvm_pkg::cmd_t      cmd_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output kvm_pkg::out_item_t out_item_o
);

  localparam int          IW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_EXEC = 2'd2;
  localparam logic [1:0] ST_READ = 2'd3;

  logic [1:0]          state_q, state_d;
  kvm_pkg::cmd_t       cur_q;
  logic [ENTRIES-1:0]  valid_q;
  logic [IW-1:0]       rd_idx_q;
  logic                rd_run_q;
  logic [IW-1:0]       chk_idx_q;
  logic                chk_vld_q;
  logic                m_found_q;
  logic [IW-1:0]       m_idx_q;
  logic                free_found_q;
  logic [IW-1:0]       free_idx_q;
  logic                out_valid_q;
  kvm_pkg::out_item_t  out_item_q;

  logic [kvm_pkg::KeyW-1:0] key_rdata;
  logic [kvm_pkg::ValW-1:0] val_rdata;
  logic                     key_we;
  logic                     val_we;
  logic [IW-1:0]            wr_idx;
  logic                     set_vld;
  logic                     clr_vld;
  logic                     res_load;
  kvm_pkg::out_item_t       res_d;
  logic                     out_free;
  logic                     chk_hit;
  logic                     chk_last;

  // Slot key and value stores; valid bits live in flip-flops.
  kvm_ram #(.WIDTH(kvm_pkg::KeyW), .DEPTH(ENTRIES), .AW(IW)) u_key_ram (
    .clk_i  (clk_i),
    .we_i   (key_we),
    .waddr_i(wr_idx),
    .wdata_i(cur_q.key),
    .raddr_i(rd_idx_q),
    .rdata_o(key_rdata)
  );

  kvm_ram #(.WIDTH(kvm_pkg::ValW), .DEPTH(ENTRIES), .AW(IW)) u_val_ram (
    .clk_i  (clk_i),
    .we_i   (val_we),
    .waddr_i(wr_idx),
    .wdata_i(cur_q.value),
    .raddr_i(m_idx_q),
    .rdata_o(val_rdata)
  );

  assign out_free  = !out_valid_q || !out_stall_i;
  assign cmd_pop_o = (state_q == ST_IDLE) && cmd_valid_i;
  assign chk_hit   = chk_vld_q && valid_q[chk_idx_q] && (key_rdata == cur_q.key);
  assign chk_last  = chk_vld_q && (chk_idx_q == LAST);

  // Next state, table updates and result formation.
  always_comb begin
    state_d  = state_q;
    key_we   = 1'b0;
    val_we   = 1'b0;
    wr_idx   = m_idx_q;
    set_vld  = 1'b0;
    clr_vld  = 1'b0;
    res_load = 1'b0;
    res_d    = '0;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          state_d = (cmd_i.op == kvm_pkg::OP_NOP) ? ST_EXEC : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (chk_hit || chk_last) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (cur_q.op == kvm_pkg::OP_GET && m_found_q) begin
          // The value store read is already addressed by the match index.
          state_d = ST_READ;
        end else if (out_free) begin
          res_load = 1'b1;
          state_d  = ST_IDLE;
          case (cur_q.op)
            kvm_pkg::OP_SET: begin
              if (m_found_q) begin
                val_we      = 1'b1;
                res_d.found = 1'b1;
              end else if (free_found_q) begin
                wr_idx  = free_idx_q;
                key_we  = 1'b1;
                val_we  = 1'b1;
                set_vld = 1'b1;
              end else begin
                res_d.table_full = 1'b1;
              end
            end
            kvm_pkg::OP_UNSET: begin
              if (m_found_q) begin
                clr_vld     = 1'b1;
                res_d.found = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_READ: begin
        if (out_free) begin
          res_load         = 1'b1;
          res_d.found      = 1'b1;
          res_d.read_value = val_rdata;
          state_d          = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Current command and the output payload.
  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cur_q <= cmd_i;
    end
    if (res_load) begin
      out_item_q <= res_d;
    end
  end

  // Control state, scan counters and valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      valid_q      <= '0;
      rd_idx_q     <= '0;
      rd_run_q     <= 1'b0;
      chk_idx_q    <= '0;
      chk_vld_q    <= 1'b0;
      m_found_q    <= 1'b0;
      m_idx_q      <= '0;
      free_found_q <= 1'b0;
      free_idx_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;

      // Start a new scan from slot zero.
      if (state_q == ST_IDLE) begin
        rd_idx_q     <= '0;
        rd_run_q     <= cmd_valid_i;
        chk_vld_q    <= 1'b0;
        m_found_q    <= 1'b0;
        free_found_q <= 1'b0;
      end

      if (state_q == ST_SCAN) begin
        // Issue side: one key read per cycle; track the lowest free slot.
        chk_vld_q <= rd_run_q;
        chk_idx_q <= rd_idx_q;
        if (rd_run_q) begin
          if (!valid_q[rd_idx_q] && !free_found_q) begin
            free_found_q <= 1'b1;
            free_idx_q   <= rd_idx_q;
          end
          if (rd_idx_q != LAST) begin
            rd_idx_q <= rd_idx_q + IW'(1);
          end
        end
        // Compare side: stop at the first matching valid slot.
        if (chk_hit) begin
          m_found_q <= 1'b1;
          m_idx_q   <= chk_idx_q;
        end
        // Reads stop after the last slot or once a match is seen.
        if (chk_hit || (rd_run_q && rd_idx_q == LAST)) begin
          rd_run_q <= 1'b0;
        end
      end

      if (set_vld) begin
        valid_q[wr_idx] <= 1'b1;
      end
      if (clr_vld) begin
        valid_q[wr_idx] <= 1'b0;
      end

      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule
